[hw/rtl/aip_pkg.sv]
package aip_pkg;

    // Accumulator width; the result port shows its low 32 bits.
    localparam int unsigned Width      = 32;
    localparam int unsigned ValueBits  = 32;
    localparam int unsigned ExtBits    = 64;
    localparam int unsigned AddrBits   = 3;

    localparam logic [AddrBits-1:0] REG_SIGNED_MODE = 3'd0;

    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
    localparam logic [7:0] CH_UP_B  = 8'h42;  // 'B'
    localparam logic [7:0] CH_UP_F  = 8'h46;  // 'F'
    localparam logic [7:0] CH_UP_X  = 8'h58;  // 'X'
    localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LO_B  = 8'h62;  // 'b'
    localparam logic [7:0] CH_LO_F  = 8'h66;  // 'f'
    localparam logic [7:0] CH_LO_X  = 8'h78;  // 'x'
    localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
    localparam logic [7:0] CH_PLUS  = 8'h2b;  // '+'

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_SIGN  = 2'd1,
        PH_ZERO  = 2'd2,
        PH_BODY  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_BIN = 2'd1,
        RX_HEX = 2'd2
    } radix_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } digit_t;

    function automatic digit_t digit_of(input logic [7:0] c, input radix_t rx);
        digit_t d;
        d.valid = 1'b0;
        d.value = 4'd0;
        if (rx == RX_BIN) begin
            if (c == CH_ZERO || c == CH_ONE) begin
                d.valid = 1'b1;
                d.value = {3'b000, c[0]};
            end
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            d.valid = 1'b1;
            d.value = c[3:0];
        end else if (rx == RX_HEX) begin
            if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F)) begin
                d.valid = 1'b1;
                d.value = 4'(c[2:0] + 3'd1) + 4'd8;  // 'A'/'a' low bits = 1
            end
        end
        return d;
    endfunction

endpackage

[hw/rtl/ascii_integer_parser_unit.sv]
// ASCII integer parser. Characters stream in on the s_ side, one per transfer,
// with s_tlast on the final one; the transfer carrying s_tlast yields one result
// (value on m_tdata, ok on m_tuser) and no other transfer yields any. Accepted:
// optional '+' or '-', then decimal digits, or 0b/0B binary or 0x/0X hex with at
// least one digit after the prefix. Overflow wraps silently; a minus sign negates
// in two's complement; a lone sign gives 0; on error value is 0 and ok is 0.
// Register signed_mode (byte address 0, reset 1) rejects '-' when cleared; write
// it only while no string is in progress. Throughput is one character per clock:
// each character is decoded and accumulated (shift, or x10 as two shifted adds)
// in the cycle it is accepted, and the result is valid in an output register the
// cycle after the last character's transfer. It can be drained in the same cycle
// as the next string's characters arrive; while a result waits with m_tready low,
// s_tready is held low.
module ascii_integer_parser_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aip_pkg::AddrBits-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // character stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] ch
    input  logic                          s_tlast,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [31:0] value
    output logic                          m_tuser    // [0] ok
);

    localparam int unsigned W = aip_pkg::Width;

    logic                     signed_mode_reg;
    aip_pkg::phase_t          phase_reg, phase_next;
    aip_pkg::radix_t          radix_reg, radix_next;
    logic                     negative_reg, negative_next;
    logic                     failed_reg, failed_next;
    logic                     dap_reg, dap_next;
    logic [W-1:0]             acc_reg, acc_next;
    logic                     m_valid_reg;
    logic [31:0]              m_data_reg, m_data_next;
    logic                     m_ok_reg, m_ok_next;

    logic                     s_xfer;
    logic                     cfg_write;
    aip_pkg::digit_t          dig;
    aip_pkg::phase_t          eff_phase;
    logic [W-1:0]             res_mag;
    logic [W-1:0]             res_val;
    logic [aip_pkg::ExtBits-1:0] res_ext;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[aip_pkg::AddrBits-1:2] == '0);
    assign prdata    = (paddr[aip_pkg::AddrBits-1:2] == '0) ? {31'd0, signed_mode_reg} : 32'd0;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_ok_reg;

    // Per-character step; a later phase is entered in the same cycle when the
    // character is not consumed by the earlier one.
    always_comb begin
        phase_next    = phase_reg;
        radix_next    = radix_reg;
        negative_next = negative_reg;
        failed_next   = failed_reg;
        dap_next      = dap_reg;
        acc_next      = acc_reg;
        eff_phase     = phase_reg;
        dig           = aip_pkg::digit_of(s_tdata, radix_reg);

        if (!failed_reg) begin
            if (phase_reg == aip_pkg::PH_START) begin
                eff_phase = aip_pkg::PH_SIGN;
                if (s_tdata == aip_pkg::CH_MINUS) begin
                    eff_phase = aip_pkg::PH_START;
                    if (signed_mode_reg) begin
                        negative_next = 1'b1;
                        phase_next    = aip_pkg::PH_SIGN;
                    end else begin
                        failed_next = 1'b1;
                    end
                end else if (s_tdata == aip_pkg::CH_PLUS) begin
                    eff_phase  = aip_pkg::PH_START;
                    phase_next = aip_pkg::PH_SIGN;
                end
            end

            if (eff_phase == aip_pkg::PH_SIGN) begin
                dig = aip_pkg::digit_of(s_tdata, aip_pkg::RX_DEC);
                if (!dig.valid) begin
                    failed_next = 1'b1;
                end else begin
                    acc_next   = W'(dig.value);
                    phase_next = (dig.value == 4'd0) ? aip_pkg::PH_ZERO : aip_pkg::PH_BODY;
                end
            end else if (eff_phase == aip_pkg::PH_ZERO || eff_phase == aip_pkg::PH_BODY) begin
                phase_next = aip_pkg::PH_BODY;
                if (eff_phase == aip_pkg::PH_ZERO &&
                    (s_tdata == aip_pkg::CH_LO_B || s_tdata == aip_pkg::CH_UP_B)) begin
                    radix_next = aip_pkg::RX_BIN;
                end else if (eff_phase == aip_pkg::PH_ZERO &&
                    (s_tdata == aip_pkg::CH_LO_X || s_tdata == aip_pkg::CH_UP_X)) begin
                    radix_next = aip_pkg::RX_HEX;
                end else if (!dig.valid) begin
                    failed_next = 1'b1;
                end else begin
                    dap_next = 1'b1;
                    case (radix_reg)
                        aip_pkg::RX_BIN: acc_next = {acc_reg[W-2:0], dig.value[0]};
                        aip_pkg::RX_HEX: acc_next = {acc_reg[W-5:0], dig.value};
                        default:         acc_next = (acc_reg << 3) + (acc_reg << 1)
                                                    + W'(dig.value);
                    endcase
                end
            end
        end

        m_ok_next   = !failed_next && (radix_next == aip_pkg::RX_DEC || dap_next);
        res_mag     = acc_next;
        res_val     = negative_next ? (~res_mag + W'(1)) : res_mag;
        res_ext     = aip_pkg::ExtBits'(res_val);
        m_data_next = m_ok_next ? res_ext[31:0] : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_mode_reg <= 1'b1;
            phase_reg       <= aip_pkg::PH_START;
            radix_reg       <= aip_pkg::RX_DEC;
            negative_reg    <= 1'b0;
            failed_reg      <= 1'b0;
            dap_reg         <= 1'b0;
            acc_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_write) begin
                signed_mode_reg <= pwdata[0];
            end
            if (s_xfer && s_tlast) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_xfer) begin
                if (s_tlast) begin
                    phase_reg    <= aip_pkg::PH_START;
                    radix_reg    <= aip_pkg::RX_DEC;
                    negative_reg <= 1'b0;
                    failed_reg   <= 1'b0;
                    dap_reg      <= 1'b0;
                    acc_reg      <= '0;
                end else begin
                    phase_reg    <= phase_next;
                    radix_reg    <= radix_next;
                    negative_reg <= negative_next;
                    failed_reg   <= failed_next;
                    dap_reg      <= dap_next;
                    acc_reg      <= acc_next;
                end
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_xfer && s_tlast) begin
            m_data_reg <= m_data_next;
            m_ok_reg   <= m_ok_next;
        end
    end

endmodule
